// ===== rtl/wvac_pkg.sv =====
// Package: shared types, constants and CORDIC arctangent table for the wind agreement check.
package wvac_pkg;

  localparam int unsigned COMP_W   = 16;
  localparam int unsigned GUARD    = 8;
  localparam int unsigned XY_W     = 28;
  localparam int unsigned ACC_W    = 32;
  localparam int unsigned MAX_STG  = 24;
  localparam int unsigned MAG_W    = 20;
  localparam logic [15:0] INV_GAIN = 16'd39797;
  localparam logic [ACC_W-1:0] HALF_TURN = 32'h0080_0000;
  localparam logic [15:0] SPEED_TOL_RST = 16'd658;
  localparam logic [15:0] ANGLE_TOL_RST = 16'd2731;

  typedef enum logic [0:0] {
    REG_SPEED_TOL = 1'b0,
    REG_ANGLE_TOL = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    FAIL_NONE  = 2'd0,
    FAIL_SPEED = 2'd1,
    FAIL_DIR   = 2'd2
  } fail_t;

  typedef struct packed {
    logic signed [15:0] predicted_east;
    logic signed [15:0] predicted_north;
    logic signed [15:0] sensed_east;
    logic signed [15:0] sensed_north;
  } in_req_t;

  typedef struct packed {
    logic       winds_agree;
    logic [1:0] failure_reason;
  } out_req_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic [ACC_W-1:0]       acc;
  } vec_t;

  typedef struct packed {
    logic vld;
    vec_t p;
    vec_t s;
  } cell_bus_t;

  function automatic logic [ACC_W-1:0] atan_lut(input logic [4:0] i);
    logic [ACC_W-1:0] r;
    unique case (i)
      5'd0:  r = 32'd2097152;
      5'd1:  r = 32'd1238021;
      5'd2:  r = 32'd654136;
      5'd3:  r = 32'd332050;
      5'd4:  r = 32'd166669;
      5'd5:  r = 32'd83416;
      5'd6:  r = 32'd41718;
      5'd7:  r = 32'd20860;
      5'd8:  r = 32'd10430;
      5'd9:  r = 32'd5215;
      5'd10: r = 32'd2608;
      5'd11: r = 32'd1304;
      5'd12: r = 32'd652;
      5'd13: r = 32'd326;
      5'd14: r = 32'd163;
      5'd15: r = 32'd81;
      5'd16: r = 32'd41;
      5'd17: r = 32'd20;
      5'd18: r = 32'd10;
      5'd19: r = 32'd5;
      5'd20: r = 32'd3;
      5'd21: r = 32'd1;
      5'd22: r = 32'd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/wvac_cell.sv =====
// CORDIC vectoring cell: one micro-rotation on both vectors per cycle while adv is high.
module wvac_cell #(
  parameter int unsigned STAGE = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  wvac_pkg::cell_bus_t  prev,
  output wvac_pkg::cell_bus_t  cur
);

  wvac_pkg::cell_bus_t cur_r, cur_nxt;

  function automatic wvac_pkg::vec_t rot(input wvac_pkg::vec_t v);
    wvac_pkg::vec_t o;
    logic signed [wvac_pkg::XY_W-1:0] xs, ys;
    logic [wvac_pkg::ACC_W-1:0] a;
    xs = v.x >>> STAGE;
    ys = v.y >>> STAGE;
    a  = wvac_pkg::atan_lut(5'(STAGE));
    if (!v.y[wvac_pkg::XY_W-1]) begin
      o.x = v.x + ys; o.y = v.y - xs; o.acc = v.acc + a;
    end else begin
      o.x = v.x - ys; o.y = v.y + xs; o.acc = v.acc - a;
    end
    return o;
  endfunction

  always_comb begin
    cur_nxt = cur_r;
    if (adv) begin
      cur_nxt.vld = prev.vld;
      cur_nxt.p   = rot(prev.p);
      cur_nxt.s   = rot(prev.s);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r.vld <= 1'b0;
    end else begin
      cur_r.vld <= cur_nxt.vld;
    end
    cur_r.p <= cur_nxt.p;
    cur_r.s <= cur_nxt.s;
  end

  assign cur = cur_r;

endmodule

// ===== rtl/wvac_judge.sv =====
// Result stages: magnitude scaling, speed and direction checks, output register.
module wvac_judge (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  wvac_pkg::cell_bus_t  chain,
  input  logic [15:0]          speed_tol,
  input  logic [15:0]          angle_tol,
  output logic                 mvld,
  output logic                 ovld,
  output wvac_pkg::out_req_t   odata
);

  logic        mvld_r, mvld_nxt, ovld_r, ovld_nxt;
  logic [wvac_pkg::MAG_W-1:0] pmag_r, pmag_nxt, smag_r, smag_nxt;
  logic [15:0] dang_r, dang_nxt;
  wvac_pkg::out_req_t odata_r, odata_nxt;

  logic [43:0] pprod, sprod;
  logic [wvac_pkg::ACC_W-1:0] pa, sa;
  logic [15:0] pang, sang;
  logic [wvac_pkg::MAG_W-1:0] sdiff;
  logic [16:0] adiff;

  always_comb begin
    pprod = 44'(unsigned'(chain.p.x)) * 44'(wvac_pkg::INV_GAIN) + 44'(1 << 23);
    sprod = 44'(unsigned'(chain.s.x)) * 44'(wvac_pkg::INV_GAIN) + 44'(1 << 23);
    pa = chain.p.acc + 32'd128;
    sa = chain.s.acc + 32'd128;
    // a zero vector leaves x at zero; force its angle to zero
    pang = (chain.p.x == '0) ? 16'd0 : pa[23:8];
    sang = (chain.s.x == '0) ? 16'd0 : sa[23:8];
    sdiff = (smag_r >= pmag_r) ? smag_r - pmag_r : pmag_r - smag_r;
    adiff = dang_r[15] ? 17'(~{1'b1, dang_r}) + 17'd1 : {1'b0, dang_r};

    mvld_nxt = mvld_r; pmag_nxt = pmag_r; smag_nxt = smag_r; dang_nxt = dang_r;
    ovld_nxt = ovld_r; odata_nxt = odata_r;
    if (adv) begin
      mvld_nxt = chain.vld;
      pmag_nxt = pprod[24 +: wvac_pkg::MAG_W];
      smag_nxt = sprod[24 +: wvac_pkg::MAG_W];
      dang_nxt = sang - pang;
      ovld_nxt = mvld_r;
      if (sdiff > {4'd0, speed_tol}) begin
        odata_nxt.winds_agree = 1'b0;
        odata_nxt.failure_reason = wvac_pkg::FAIL_SPEED;
      end else if (adiff > {1'b0, angle_tol}) begin
        odata_nxt.winds_agree = 1'b0;
        odata_nxt.failure_reason = wvac_pkg::FAIL_DIR;
      end else begin
        odata_nxt.winds_agree = 1'b1;
        odata_nxt.failure_reason = wvac_pkg::FAIL_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mvld_r <= 1'b0;
      ovld_r <= 1'b0;
    end else begin
      mvld_r <= mvld_nxt;
      ovld_r <= ovld_nxt;
    end
    pmag_r  <= pmag_nxt;
    smag_r  <= smag_nxt;
    dang_r  <= dang_nxt;
    odata_r <= odata_nxt;
  end

  assign mvld  = mvld_r;
  assign ovld  = ovld_r;
  assign odata = odata_r;

endmodule

// ===== rtl/wind_vector_agreement_check_unit.sv =====
// Top level: wind vector agreement check with a pipelined CORDIC cell chain.
// One request enters per cycle while in_stall is low. With N = min(CORDIC_STAGES, 24),
// a request passes through N + 3 registers on its way to the verdict on out_valid:
// a pre-rotation register, one cell per CORDIC stage, a magnitude/angle register
// and the result register. The whole pipeline, empty slots included, holds while
// the result is stalled, so each stalled cycle with a waiting result also blocks
// the input. Tolerances reset to 10 knots and 15 degrees.
module wind_vector_agreement_check_unit #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  wvac_pkg::in_req_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output wvac_pkg::out_req_t  out_data,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [15:0]         cfg_wdata
);

  localparam int unsigned NSTG = (CORDIC_STAGES > wvac_pkg::MAX_STG) ?
                                 wvac_pkg::MAX_STG : CORDIC_STAGES;

  logic [15:0] speed_tol_r, speed_tol_nxt, angle_tol_r, angle_tol_nxt;
  wvac_pkg::cell_bus_t head_r, head_nxt;
  wvac_pkg::cell_bus_t bus [NSTG+1];
  logic adv, mvld;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  function automatic wvac_pkg::vec_t prerot(input logic signed [15:0] e,
                                            input logic signed [15:0] n);
    wvac_pkg::vec_t v;
    logic signed [wvac_pkg::XY_W-1:0] x, y;
    x = wvac_pkg::XY_W'(e) <<< wvac_pkg::GUARD;
    y = wvac_pkg::XY_W'(n) <<< wvac_pkg::GUARD;
    if (e == 16'sd0 && n == 16'sd0) begin
      v.x = '0; v.y = '0; v.acc = '0;
    end else if (e[15]) begin
      v.x = -x; v.y = -y; v.acc = wvac_pkg::HALF_TURN;
    end else begin
      v.x = x; v.y = y; v.acc = '0;
    end
    return v;
  endfunction

  always_comb begin
    speed_tol_nxt = speed_tol_r;
    angle_tol_nxt = angle_tol_r;
    if (cfg_we) begin
      unique case (cfg_index)
        wvac_pkg::REG_SPEED_TOL: speed_tol_nxt = cfg_wdata;
        wvac_pkg::REG_ANGLE_TOL: angle_tol_nxt = cfg_wdata;
        default: ;
      endcase
    end
    head_nxt = head_r;
    if (adv) begin
      head_nxt.vld = in_valid;
      head_nxt.p   = prerot(in_data.predicted_east, in_data.predicted_north);
      head_nxt.s   = prerot(in_data.sensed_east, in_data.sensed_north);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_tol_r <= wvac_pkg::SPEED_TOL_RST;
      angle_tol_r <= wvac_pkg::ANGLE_TOL_RST;
      head_r.vld  <= 1'b0;
    end else begin
      speed_tol_r <= speed_tol_nxt;
      angle_tol_r <= angle_tol_nxt;
      head_r.vld  <= head_nxt.vld;
    end
    head_r.p <= head_nxt.p;
    head_r.s <= head_nxt.s;
  end

  assign bus[0] = head_r;

  for (genvar g = 0; g < NSTG; g++) begin : g_cell
    wvac_cell #(.STAGE(g)) u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .adv  (adv),
      .prev (bus[g]),
      .cur  (bus[g+1])
    );
  end

  wvac_judge u_judge (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .chain    (bus[NSTG]),
    .speed_tol(speed_tol_r),
    .angle_tol(angle_tol_r),
    .mvld     (mvld),
    .ovld     (out_valid),
    .odata    (out_data)
  );

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result dropped under stall");
  a_agree: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.winds_agree == (out_data.failure_reason == wvac_pkg::FAIL_NONE)))
    else $error("agree flag disagrees with reason");
  a_feed: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall && mvld |=> out_valid)
    else $error("result lost between stages");

endmodule

// ===== verif/wind_vector_agreement_check_unit_tb.sv =====
// Testbench for the wind vector agreement check: directed and random vector pairs against a model.
`timescale 1ns / 1ps
module wind_vector_agreement_check_unit_tb;

  localparam int unsigned STAGES = 16;
  localparam int unsigned LATENCY = STAGES + 3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  wvac_pkg::in_req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  wvac_pkg::out_req_t out_data;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = wvac_pkg::REG_SPEED_TOL;
  logic [15:0] cfg_wdata = '0;

  logic [15:0] speed_tol = wvac_pkg::SPEED_TOL_RST;
  logic [15:0] angle_tol = wvac_pkg::ANGLE_TOL_RST;
  wvac_pkg::out_req_t verdict_q[$];
  int unsigned mismatches = 0;
  int unsigned verdicts_seen = 0;
  int unsigned agree_seen = 0, speed_fail_seen = 0, dir_fail_seen = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  wind_vector_agreement_check_unit #(.CORDIC_STAGES(STAGES)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic logic [31:0] atan_step(input int i);
    logic [31:0] t[24] = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
                           10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3,
                           1, 1, 0};
    return t[i];
  endfunction

  function automatic void cordic_polar(input logic signed [15:0] e,
                                       input logic signed [15:0] n,
                                       output logic [31:0] mag, output logic [15:0] ang);
    longint x, y, xs, ys;
    logic [31:0] acc;
    logic [63:0] prod;
    acc = '0;
    x = e;
    y = n;
    if (x == 0 && y == 0) begin
      mag = 0;
      ang = 0;
      return;
    end
    if (x < 0) begin
      x = -x;
      y = -y;
      acc = wvac_pkg::HALF_TURN;
    end
    x = x * 256;
    y = y * 256;
    for (int i = 0; i < STAGES && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        acc = acc + atan_step(i);
      end else begin
        x = x - ys;
        y = y + xs;
        acc = acc - atan_step(i);
      end
    end
    prod = 64'(x) * 64'd39797 + 64'd8388608;
    mag = 32'(prod >> 24);
    ang = 16'((acc + 32'd128) >> 8);
  endfunction

  function automatic wvac_pkg::out_req_t judge_winds(input wvac_pkg::in_req_t r);
    logic [31:0] pm, sm, sdiff;
    logic [15:0] pa, sa, d;
    logic [16:0] adiff;
    wvac_pkg::out_req_t v;
    cordic_polar(r.predicted_east, r.predicted_north, pm, pa);
    cordic_polar(r.sensed_east, r.sensed_north, sm, sa);
    sdiff = (sm >= pm) ? sm - pm : pm - sm;
    d = sa - pa;
    adiff = d[15] ? 17'(-$signed({1'b1, d})) : 17'(d);
    if (sdiff > speed_tol) begin
      v.winds_agree = 1'b0;
      v.failure_reason = wvac_pkg::FAIL_SPEED;
    end else if (adiff > angle_tol) begin
      v.winds_agree = 1'b0;
      v.failure_reason = wvac_pkg::FAIL_DIR;
    end else begin
      v.winds_agree = 1'b1;
      v.failure_reason = wvac_pkg::FAIL_NONE;
    end
    return v;
  endfunction

  // random stall on the result side, decided per edge
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      verdicts_seen++;
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected verdict %p", out_data);
      end else begin
        wvac_pkg::out_req_t exp_v;
        exp_v = verdict_q.pop_front();
        if (out_data.winds_agree !== exp_v.winds_agree ||
            out_data.failure_reason !== exp_v.failure_reason) begin
          mismatches++;
          if (mismatches <= 10)
            $display("verdict mismatch: expected %p actual %p", exp_v, out_data);
        end
        case (exp_v.failure_reason)
          wvac_pkg::FAIL_NONE: agree_seen++;
          wvac_pkg::FAIL_SPEED: speed_fail_seen++;
          default: dir_fail_seen++;
        endcase
      end
    end
  end

  task automatic send_pair(input wvac_pkg::in_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    verdict_q.push_back(judge_winds(r));
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain;
    int unsigned guard;
    guard = 0;
    in_valid <= 1'b0;
    while (verdict_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_tol(input wvac_pkg::reg_idx_t idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == wvac_pkg::REG_SPEED_TOL) speed_tol = val;
    else angle_tol = val;
    @(posedge clk);
  endtask

  function automatic wvac_pkg::in_req_t pair(input int pe, input int pn, input int se,
                                             input int sn);
    wvac_pkg::in_req_t r;
    r.predicted_east = 16'(pe);
    r.predicted_north = 16'(pn);
    r.sensed_east = 16'(se);
    r.sensed_north = 16'(sn);
    return r;
  endfunction

  function automatic logic [15:0] rand_comp;
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(400)) - 200);
      2: return $urandom_range(1) ? 16'h8000 : 16'h7fff;
      default: return 16'($signed($urandom_range(8000)) - 4000);
    endcase
  endfunction

  // sensed near predicted so both checks are exercised
  function automatic wvac_pkg::in_req_t rand_pair;
    wvac_pkg::in_req_t r;
    r.predicted_east = rand_comp();
    r.predicted_north = rand_comp();
    if ($urandom_range(99) < 70) begin
      r.sensed_east = r.predicted_east + 16'($signed($urandom_range(800)) - 400);
      r.sensed_north = r.predicted_north + 16'($signed($urandom_range(800)) - 400);
    end else begin
      r.sensed_east = rand_comp();
      r.sensed_north = rand_comp();
    end
    return r;
  endfunction

  task automatic test_directed;
    send_pair(pair(0, 0, 0, 0));
    send_pair(pair(0, 0, 1, 0));
    send_pair(pair(-32768, -32768, -32768, -32768));
    send_pair(pair(32767, 32767, -32768, -32768));
    send_pair(pair(32767, 0, -32768, 0));
    send_pair(pair(1000, 0, -1000, 0));
    send_pair(pair(0, 1000, 0, -1000));
    send_pair(pair(-1000, 1, -1000, -1));
    send_pair(pair(1280, 0, 1280, 340));
    send_pair(pair(1280, 0, 1280, 360));
    send_pair(pair(1280, 0, 1938, 0));
    send_pair(pair(1280, 0, 1950, 0));
    send_pair(pair(0, 32767, 0, -32768));
    send_pair(pair(-1, -1, 1, 1));
    send_pair(pair(-32768, 0, 0, -32768));
    drain();
  endtask

  task automatic test_tolerance_extremes;
    write_tol(wvac_pkg::REG_ANGLE_TOL, 16'd32768);
    write_tol(wvac_pkg::REG_SPEED_TOL, 16'hffff);
    send_pair(pair(1000, 0, -1000, 0));
    send_pair(pair(0, 1000, 0, -1000));
    send_pair(pair(-32768, -32768, 5, 0));
    drain();
    write_tol(wvac_pkg::REG_ANGLE_TOL, 16'd32767);
    write_tol(wvac_pkg::REG_SPEED_TOL, 16'd0);
    send_pair(pair(1000, 0, -1000, 0));
    send_pair(pair(1000, 0, 1000, 0));
    send_pair(pair(0, 0, 0, 0));
    drain();
    write_tol(wvac_pkg::REG_ANGLE_TOL, 16'd0);
    send_pair(pair(1000, 3, 1000, 3));
    send_pair(pair(1000, 3, 1000, 4));
    drain();
  endtask

  task automatic test_random_phase(input int unsigned n, input int unsigned idle,
                                   input int unsigned stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int unsigned k = 0; k < n; k++) begin
      send_pair(rand_pair());
      // hold off until every verdict is back
      if (k == n / 2) begin
        in_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge clk);
      end
    end
    drain();
    recv_stall_pct = 0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_tolerance_extremes();
    write_tol(wvac_pkg::REG_SPEED_TOL, wvac_pkg::SPEED_TOL_RST);
    write_tol(wvac_pkg::REG_ANGLE_TOL, wvac_pkg::ANGLE_TOL_RST);
    test_random_phase(350, 0, 0);
    write_tol(wvac_pkg::REG_SPEED_TOL, 16'(300 + $urandom_range(3000)));
    write_tol(wvac_pkg::REG_ANGLE_TOL, 16'($urandom_range(32768)));
    test_random_phase(350, 62, 0);
    write_tol(wvac_pkg::REG_SPEED_TOL, 16'($urandom_range(65535)));
    write_tol(wvac_pkg::REG_ANGLE_TOL, 16'($urandom_range(6000)));
    test_random_phase(350, 0, 62);
    write_tol(wvac_pkg::REG_SPEED_TOL, wvac_pkg::SPEED_TOL_RST);
    write_tol(wvac_pkg::REG_ANGLE_TOL, wvac_pkg::ANGLE_TOL_RST);
    test_random_phase(350, 21, 21);
    if (verdict_q.size() != 0) mismatches += verdict_q.size();
    $display("covered %0d verdicts: %0d agree, %0d speed, %0d direction; tolerance extremes",
             verdicts_seen, agree_seen, speed_fail_seen, dir_fail_seen);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("status: fail");
    end
    $finish;
  end

endmodule
